>>> sv/color_combine_unit_macros.svh
// ----------------------------------------------------------------------------
// color_combine_unit_macros
// Assertion macros shared by the color combine unit.
// ----------------------------------------------------------------------------
`ifndef COLOR_COMBINE_UNIT_MACROS_SVH
`define COLOR_COMBINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ccu_pkg.sv
// ----------------------------------------------------------------------------
// ccu_pkg
// Command codes and fixed port widths of the color combine unit.
// ----------------------------------------------------------------------------
package ccu_pkg;

    localparam int PORT_BITS = 8;
    localparam int CMD_BITS  = 4;

    typedef logic [CMD_BITS-1:0]  cmd_t;
    typedef logic [PORT_BITS-1:0] port_chan_t;

    localparam cmd_t CMD_LOAD      = 4'd0;
    localparam cmd_t CMD_ADD       = 4'd1;
    localparam cmd_t CMD_ALPHA_ADD = 4'd2;
    localparam cmd_t CMD_SUB       = 4'd3;
    localparam cmd_t CMD_ALPHA_SUB = 4'd4;
    localparam cmd_t CMD_MODULATE  = 4'd5;
    localparam cmd_t CMD_BLEND     = 4'd6;
    localparam cmd_t CMD_LIGHTER   = 4'd7;
    localparam cmd_t CMD_DARKER    = 4'd8;

endpackage

>>> sv/ccu_chan.sv
// ----------------------------------------------------------------------------
// ccu_chan
// One color channel of the combine datapath: saturating add and subtract,
// scaled products, blend and min/max, with one shared multiplier.
// ----------------------------------------------------------------------------
module ccu_chan #(
    parameter int CHANNEL_BITS = 8,
    parameter bit IS_ALPHA     = 1'b0
) (
    input  ccu_pkg::cmd_t            command,
    input  logic [CHANNEL_BITS-1:0]  cur,
    input  logic [CHANNEL_BITS-1:0]  arg,
    input  logic [CHANNEL_BITS-1:0]  weight,
    output logic [CHANNEL_BITS-1:0]  result
);
    import ccu_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam logic [N-1:0]   CH_MAX   = {N{1'b1}};
    localparam logic [2*N-1:0] ROUND_UP = (2*N)'(CH_MAX);

    logic           arg_ge;
    logic [N-1:0]   delta;
    logic [N-1:0]   mul_x;
    logic [N-1:0]   mul_y;
    logic [2*N-1:0] prod;
    logic [2*N-1:0] prod_up;
    logic [N-1:0]   scaled;
    logic [N-1:0]   scaled_up;
    logic [N-1:0]   addend;
    logic [N:0]     sum;
    logic [N-1:0]   add_sat;
    logic [N-1:0]   sub_sat;

    assign arg_ge = (arg >= cur);
    assign delta  = arg_ge ? (arg - cur) : (cur - arg);

    // operand select for the shared multiplier
    always_comb begin
        priority if (command == CMD_MODULATE) begin
            mul_x = cur;
            mul_y = arg;
        end else if (command == CMD_BLEND) begin
            mul_x = delta;
            mul_y = weight;
        end else begin
            mul_x = arg;
            mul_y = weight;
        end
    end

    assign prod      = (2*N)'(mul_x) * (2*N)'(mul_y);
    assign prod_up   = prod + ROUND_UP;
    assign scaled    = prod[2*N-1:N];
    assign scaled_up = prod_up[2*N-1:N];

    // rgb channels take the alpha-weighted argument for the weighted ops
    assign addend = (!IS_ALPHA && (command == CMD_ALPHA_ADD || command == CMD_ALPHA_SUB))
                    ? scaled : arg;

    assign sum     = {1'b0, cur} + {1'b0, addend};
    assign add_sat = sum[N] ? CH_MAX : sum[N-1:0];
    assign sub_sat = (addend >= cur) ? '0 : (cur - addend);

    always_comb begin
        unique case (command)
            CMD_LOAD:                result = arg;
            CMD_ADD, CMD_ALPHA_ADD:  result = add_sat;
            CMD_SUB, CMD_ALPHA_SUB:  result = sub_sat;
            CMD_MODULATE:            result = scaled;
            CMD_BLEND: begin
                if (IS_ALPHA) begin
                    result = cur;
                end else begin
                    result = arg_ge ? (cur + scaled) : (cur - scaled_up);
                end
            end
            CMD_LIGHTER:             result = (IS_ALPHA || !arg_ge) ? cur : arg;
            CMD_DARKER:              result = (IS_ALPHA || arg_ge) ? cur : arg;
            default:                 result = cur;
        endcase
    end

endmodule

>>> sv/color_combine_unit.sv
// ----------------------------------------------------------------------------
// color_combine_unit
// ARGB point color combine unit with valid/ready word channels.
//
// The s_ channel carries a command and an argument color; the m_ channel
// returns the point color after that command, one word per input word.
// A word is taken into an input register, combined with the stored point
// color in one pass through the per-channel datapath, and written both to
// the point color register and to the output register.
// An accepted word passes the input and then the output register to m_valid.
// Throughput: one word per cycle without receiver stalls, set by the point color loop.
// Reset (aresetn low, synchronous) clears the point color to zero and
// empties both the input and output registers.
// When the receiver stalls, the output word holds; one more word can wait
// in the input register, after which s_ready falls until m_ready returns.
// ----------------------------------------------------------------------------
module color_combine_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ccu_pkg::cmd_t          s_command,
    input  ccu_pkg::port_chan_t    s_arg_alpha,
    input  ccu_pkg::port_chan_t    s_arg_red,
    input  ccu_pkg::port_chan_t    s_arg_green,
    input  ccu_pkg::port_chan_t    s_arg_blue,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ccu_pkg::port_chan_t    m_out_alpha,
    output ccu_pkg::port_chan_t    m_out_red,
    output ccu_pkg::port_chan_t    m_out_green,
    output ccu_pkg::port_chan_t    m_out_blue
);
    import ccu_pkg::*;

    `include "color_combine_unit_macros.svh"

    localparam int NUM_CHANS = 4;

    logic                    in_valid_reg;
    cmd_t                    cmd_reg;
    port_chan_t              arg_reg   [NUM_CHANS];
    logic [CHANNEL_BITS-1:0] arg_ext   [NUM_CHANS];
    logic [CHANNEL_BITS-1:0] color_reg [NUM_CHANS];
    logic [CHANNEL_BITS-1:0] color_next[NUM_CHANS];
    logic                    m_valid_reg;
    port_chan_t              m_out_reg [NUM_CHANS];
    logic                    out_free;
    logic                    advance;
    logic                    in_take;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg    <= s_command;
            arg_reg[0] <= s_arg_alpha;
            arg_reg[1] <= s_arg_red;
            arg_reg[2] <= s_arg_green;
            arg_reg[3] <= s_arg_blue;
        end
    end

    // per-channel datapath, channel 0 is alpha
    for (genvar i = 0; i < NUM_CHANS; i++) begin : g_chan
        assign arg_ext[i] = CHANNEL_BITS'(arg_reg[i]);

        ccu_chan #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .IS_ALPHA     (i == 0)
        ) u_chan (
            .command (cmd_reg),
            .cur     (color_reg[i]),
            .arg     (arg_ext[i]),
            .weight  (arg_ext[0]),
            .result  (color_next[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                color_reg[i] <= '0;
            end else if (advance) begin
                color_reg[i] <= color_next[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                m_out_reg[i] <= color_next[i][PORT_BITS-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_alpha = m_out_reg[0];
    assign m_out_red   = m_out_reg[1];
    assign m_out_green = m_out_reg[2];
    assign m_out_blue  = m_out_reg[3];

    `CCU_ASSERT_NEXT(a_word_moves_out, advance, m_valid_reg, "word lost between stages")
    `CCU_ASSERT_NEXT(a_take_fills, in_take, in_valid_reg, "accepted word not registered")
    `CCU_ASSERT_NEXT(a_out_matches_color, advance,
        m_out_reg[1] == color_reg[1][PORT_BITS-1:0] &&
        m_out_reg[0] == color_reg[0][PORT_BITS-1:0],
        "output word differs from point color")
    `CCU_ASSERT_NOW(a_full_stall, in_valid_reg && m_valid_reg && !m_ready, !s_ready,
        "input accepted while both stages are full")

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color combine unit.
//
// A scoreboard keeps its own copy of the point color, works out the color
// that every accepted input word should produce and checks each output word
// against the oldest prediction, field by field. The sender runs in bursts
// with random gaps and the receiver stalls in changing patterns. A short
// directed run hits the channel extremes, saturation, blend rounding and the
// unused command codes; random words with frequent loads follow.
// ----------------------------------------------------------------------------
module tb;
    import ccu_pkg::*;

    localparam int NUM_RANDOM  = 1400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        port_chan_t alpha;
        port_chan_t red;
        port_chan_t green;
        port_chan_t blue;
    } argb_t;

    class color_scoreboard;
        argb_t point;
        argb_t predicted_colors[$];
        int    mismatches;
        int    words_in;
        int    words_out;
        int    cmd_count[16];

        function new();
            point      = '0;
            mismatches = 0;
            words_in   = 0;
            words_out  = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
        endfunction

        function port_chan_t sat_sum(int x, int y);
            int s;
            s = x + y;
            if (s > 255) s = 255;
            if (s < 0) s = 0;
            return port_chan_t'(s);
        endfunction

        function port_chan_t scaled(int x, int y);
            return port_chan_t'((x * y) >> 8);
        endfunction

        function port_chan_t blended(int c, int g, int a);
            int d;
            d = (g - c) * a;
            return port_chan_t'(c + (d >>> 8));
        endfunction

        // update the point color for one accepted word and queue the result
        function void note_word(cmd_t cmd, argb_t arg);
            argb_t c;
            c = point;
            case (cmd)
                CMD_LOAD: c = arg;
                CMD_ADD: begin
                    c.alpha = sat_sum(c.alpha, arg.alpha);
                    c.red   = sat_sum(c.red, arg.red);
                    c.green = sat_sum(c.green, arg.green);
                    c.blue  = sat_sum(c.blue, arg.blue);
                end
                CMD_ALPHA_ADD: begin
                    c.alpha = sat_sum(c.alpha, arg.alpha);
                    c.red   = sat_sum(c.red, scaled(arg.red, arg.alpha));
                    c.green = sat_sum(c.green, scaled(arg.green, arg.alpha));
                    c.blue  = sat_sum(c.blue, scaled(arg.blue, arg.alpha));
                end
                CMD_SUB: begin
                    c.alpha = sat_sum(c.alpha, -int'(arg.alpha));
                    c.red   = sat_sum(c.red, -int'(arg.red));
                    c.green = sat_sum(c.green, -int'(arg.green));
                    c.blue  = sat_sum(c.blue, -int'(arg.blue));
                end
                CMD_ALPHA_SUB: begin
                    c.alpha = sat_sum(c.alpha, -int'(arg.alpha));
                    c.red   = sat_sum(c.red, -int'(scaled(arg.red, arg.alpha)));
                    c.green = sat_sum(c.green, -int'(scaled(arg.green, arg.alpha)));
                    c.blue  = sat_sum(c.blue, -int'(scaled(arg.blue, arg.alpha)));
                end
                CMD_MODULATE: begin
                    c.alpha = scaled(c.alpha, arg.alpha);
                    c.red   = scaled(c.red, arg.red);
                    c.green = scaled(c.green, arg.green);
                    c.blue  = scaled(c.blue, arg.blue);
                end
                CMD_BLEND: begin
                    c.red   = blended(c.red, arg.red, arg.alpha);
                    c.green = blended(c.green, arg.green, arg.alpha);
                    c.blue  = blended(c.blue, arg.blue, arg.alpha);
                end
                CMD_LIGHTER: begin
                    if (arg.red > c.red) c.red = arg.red;
                    if (arg.green > c.green) c.green = arg.green;
                    if (arg.blue > c.blue) c.blue = arg.blue;
                end
                CMD_DARKER: begin
                    if (arg.red < c.red) c.red = arg.red;
                    if (arg.green < c.green) c.green = arg.green;
                    if (arg.blue < c.blue) c.blue = arg.blue;
                end
                default: ;
            endcase
            point = c;
            predicted_colors.push_back(c);
            words_in++;
            cmd_count[cmd]++;
        endfunction

        function void check_word(argb_t got);
            argb_t want;
            words_out++;
            if (predicted_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output word %h with nothing pending", got);
                return;
            end
            want = predicted_colors.pop_front();
            if (got.alpha !== want.alpha || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch on output word %0d:", words_out,
                             " expected a=%h r=%h g=%h b=%h,",
                             want.alpha, want.red, want.green, want.blue,
                             " got a=%h r=%h g=%h b=%h",
                             got.alpha, got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return predicted_colors.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    cmd_t       s_command;
    port_chan_t s_arg_alpha;
    port_chan_t s_arg_red;
    port_chan_t s_arg_green;
    port_chan_t s_arg_blue;
    logic       m_valid;
    logic       m_ready;
    port_chan_t m_out_alpha;
    port_chan_t m_out_red;
    port_chan_t m_out_green;
    port_chan_t m_out_blue;

    color_scoreboard sb;
    int idle_cycles;
    int burst_left;
    int ready_mode;
    int mode_left;

    color_combine_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_arg_alpha (s_arg_alpha),
        .s_arg_red   (s_arg_red),
        .s_arg_green (s_arg_green),
        .s_arg_blue  (s_arg_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_alpha (m_out_alpha),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // monitor both channels and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(s_command, {s_arg_alpha, s_arg_red, s_arg_green, s_arg_blue});
            if (m_valid && m_ready)
                sb.check_word({m_out_alpha, m_out_red, m_out_green, m_out_blue});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver stall patterns, changed every so often
    always @(negedge aclk) begin
        if (aresetn !== 1'b1) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= ($urandom_range(0, 29) != 0) ? m_ready : ~m_ready;
            endcase
        end
    end

    // present one word, hold it until taken, then maybe open a gap
    task send_word(input cmd_t cmd, input argb_t arg);
        s_valid     = 1'b1;
        s_command   = cmd;
        s_arg_alpha = arg.alpha;
        s_arg_red   = arg.red;
        s_arg_green = arg.green;
        s_arg_blue  = arg.blue;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    function port_chan_t pick_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return port_chan_t'($urandom_range(0, 3));
            default: return port_chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CMD_LOAD;
        if (r < 95) return cmd_t'($urandom_range(CMD_ADD, CMD_DARKER));
        return cmd_t'($urandom_range(9, 15));
    endfunction

    initial begin
        sb          = new();
        idle_cycles = 0;
        burst_left  = 0;
        ready_mode  = 0;
        mode_left   = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_command   = CMD_LOAD;
        s_arg_alpha = '0;
        s_arg_red   = '0;
        s_arg_green = '0;
        s_arg_blue  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words
        send_word(CMD_ADD,       {8'h00, 8'h00, 8'h00, 8'h00});
        send_word(CMD_LOAD,      {8'hff, 8'hff, 8'hff, 8'hff});
        send_word(CMD_ADD,       {8'hff, 8'h01, 8'h80, 8'hff});
        send_word(CMD_SUB,       {8'h01, 8'hff, 8'h7f, 8'h00});
        send_word(CMD_SUB,       {8'hff, 8'hff, 8'hff, 8'hff});
        send_word(CMD_LOAD,      {8'h40, 8'h80, 8'hc0, 8'h10});
        send_word(CMD_ALPHA_ADD, {8'h00, 8'hff, 8'hff, 8'hff});
        send_word(CMD_ALPHA_ADD, {8'hff, 8'hff, 8'h80, 8'h01});
        send_word(CMD_ALPHA_SUB, {8'h80, 8'hff, 8'h40, 8'h02});
        send_word(CMD_ALPHA_SUB, {8'hff, 8'hff, 8'hff, 8'hff});
        send_word(CMD_LOAD,      {8'hff, 8'hff, 8'h80, 8'h01});
        send_word(CMD_MODULATE,  {8'hff, 8'hff, 8'hff, 8'hff});
        send_word(CMD_MODULATE,  {8'h00, 8'h80, 8'h00, 8'hff});
        send_word(CMD_LOAD,      {8'h20, 8'h10, 8'hf0, 8'h55});
        send_word(CMD_BLEND,     {8'hff, 8'hf0, 8'h10, 8'h55});
        send_word(CMD_BLEND,     {8'h00, 8'h00, 8'hff, 8'h00});
        send_word(CMD_BLEND,     {8'h01, 8'h00, 8'hff, 8'h54});
        send_word(CMD_BLEND,     {8'h80, 8'hff, 8'h00, 8'h55});
        send_word(CMD_LOAD,      {8'h7f, 8'h80, 8'h80, 8'h80});
        send_word(CMD_LIGHTER,   {8'h00, 8'hff, 8'h00, 8'h80});
        send_word(CMD_DARKER,    {8'hff, 8'h00, 8'hff, 8'h80});
        send_word(cmd_t'(9),     {8'h12, 8'h34, 8'h56, 8'h78});
        send_word(cmd_t'(15),    {8'hff, 8'hff, 8'hff, 8'hff});

        // random words
        repeat (NUM_RANDOM)
            send_word(pick_cmd(), {pick_chan(), pick_chan(), pick_chan(), pick_chan()});
        s_valid = 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches > MAX_REPORTS)
            $display("%0d further mismatches not shown", sb.mismatches - MAX_REPORTS);
        $display("run covered %0d input words and %0d output words under random stalls",
                 sb.words_in, sb.words_out);
        $display("blend %0d, modulate %0d, alpha add %0d, alpha subtract %0d, unused codes %0d",
                 sb.cmd_count[CMD_BLEND], sb.cmd_count[CMD_MODULATE],
                 sb.cmd_count[CMD_ALPHA_ADD], sb.cmd_count[CMD_ALPHA_SUB],
                 sb.words_in - sb.cmd_count[CMD_LOAD] - sb.cmd_count[CMD_ADD]
                 - sb.cmd_count[CMD_ALPHA_ADD] - sb.cmd_count[CMD_SUB]
                 - sb.cmd_count[CMD_ALPHA_SUB] - sb.cmd_count[CMD_MODULATE]
                 - sb.cmd_count[CMD_BLEND] - sb.cmd_count[CMD_LIGHTER]
                 - sb.cmd_count[CMD_DARKER]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
